// ===== sv/pgc_pkg.sv =====
`default_nettype none

package pgc_pkg;

    // Field widths fixed by the item formats.
    localparam int COORD_W    = 5;
    localparam int COMP_W     = 16;
    localparam int VEC_W      = 3 * COMP_W;
    localparam int CURL_W     = 26;
    localparam int GRID_W     = 6;
    localparam int INV_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int ACC_W      = COMP_W + 2;
    localparam int PROD_W     = ACC_W + INV_W + 1;
    localparam int FRAC_SHIFT = 8;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [GRID_W-1:0] GRID_SIZE_RESET   = 6'd32;
    localparam logic [INV_W-1:0]  INV_SPACING_RESET = 16'd256;

    // Neighbor read order of a query.
    localparam logic [2:0] RD_JP   = 3'd0;
    localparam logic [2:0] RD_JM   = 3'd1;
    localparam logic [2:0] RD_KP   = 3'd2;
    localparam logic [2:0] RD_KM   = 3'd3;
    localparam logic [2:0] RD_IP   = 3'd4;
    localparam logic [2:0] RD_IM   = 3'd5;
    localparam logic [2:0] RD_LAST = 3'd6;

    // Last multiply step (one per curl component).
    localparam logic [1:0] MUL_LAST = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_ERROR
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DONE
    } state_t;

    // Command handed from the front to the back.
    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] ci;
        logic [COORD_W-1:0] cj;
        logic [COORD_W-1:0] ck;
        logic [COORD_W-1:0] ip;
        logic [COORD_W-1:0] im;
        logic [COORD_W-1:0] jp;
        logic [COORD_W-1:0] jm;
        logic [COORD_W-1:0] kp;
        logic [COORD_W-1:0] km;
        logic [VEC_W-1:0]   vec;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/pgc_if.sv =====
`default_nettype none

// Input item channel.
interface pgc_item_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [pgc_pkg::COORD_W-1:0]         coord_i;
    logic [pgc_pkg::COORD_W-1:0]         coord_j;
    logic [pgc_pkg::COORD_W-1:0]         coord_k;
    logic signed [pgc_pkg::COMP_W-1:0]   vec_x;
    logic signed [pgc_pkg::COMP_W-1:0]   vec_y;
    logic signed [pgc_pkg::COMP_W-1:0]   vec_z;

    modport source (
        output valid, kind, coord_i, coord_j, coord_k, vec_x, vec_y, vec_z,
        input  ready
    );
    modport sink (
        input  valid, kind, coord_i, coord_j, coord_k, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

// Result channel.
interface pgc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [pgc_pkg::CURL_W-1:0]   curl_x;
    logic signed [pgc_pkg::CURL_W-1:0]   curl_y;
    logic signed [pgc_pkg::CURL_W-1:0]   curl_z;
    logic                                coord_error;

    modport source (
        output valid, curl_x, curl_y, curl_z, coord_error,
        input  ready
    );
    modport sink (
        input  valid, curl_x, curl_y, curl_z, coord_error,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/pgc_ram.sv =====
`default_nettype none

// Single-port RAM with registered read data.
module pgc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

`default_nettype wire

// ===== sv/pgc_front.sv =====
`default_nettype none

// Front end: takes items, checks coordinates against the grid and works out
// the wrapped neighbor coordinates of queries.
module pgc_front #(
    parameter int EDGE_MAX = 32
) (
    pgc_item_if.sink                          item,
    input  wire logic [pgc_pkg::GRID_W-1:0]   grid_size,
    input  wire logic                         full,
    output logic                              push,
    output pgc_pkg::cmd_t                     cmd
);

    localparam int LIMIT_INT = (EDGE_MAX < 32) ? EDGE_MAX : 32;
    localparam logic [pgc_pkg::GRID_W-1:0] LIMIT = pgc_pkg::GRID_W'(LIMIT_INT);

    logic [pgc_pkg::GRID_W-1:0]  edge_n;
    logic                        in_grid;
    logic                        accept;
    logic [pgc_pkg::COORD_W-1:0] edge_m1;

    // Effective edge length and range check.
    always_comb
    begin
        edge_n  = (grid_size < LIMIT) ? grid_size : LIMIT;
        edge_m1 = pgc_pkg::COORD_W'(edge_n - pgc_pkg::GRID_W'(1));
        in_grid = ({1'b0, item.coord_i} < edge_n) &&
                  ({1'b0, item.coord_j} < edge_n) &&
                  ({1'b0, item.coord_k} < edge_n);
    end

    assign item.ready = !full;
    assign accept     = item.valid && !full;

    // Loads outside the grid are dropped here; everything else is queued.
    assign push = accept && (in_grid || (item.kind == pgc_pkg::KIND_QUERY));

    // Command build with periodic wrap of the plus and minus neighbors.
    always_comb
    begin
        if (item.kind == pgc_pkg::KIND_LOAD)
        begin
            cmd.op = pgc_pkg::OP_LOAD;
        end
        else if (in_grid)
        begin
            cmd.op = pgc_pkg::OP_QUERY;
        end
        else
        begin
            cmd.op = pgc_pkg::OP_ERROR;
        end
        cmd.ci  = item.coord_i;
        cmd.cj  = item.coord_j;
        cmd.ck  = item.coord_k;
        cmd.ip  = (({1'b0, item.coord_i} + 6'd1) == edge_n) ? '0 : item.coord_i + 5'd1;
        cmd.jp  = (({1'b0, item.coord_j} + 6'd1) == edge_n) ? '0 : item.coord_j + 5'd1;
        cmd.kp  = (({1'b0, item.coord_k} + 6'd1) == edge_n) ? '0 : item.coord_k + 5'd1;
        cmd.im  = (item.coord_i == '0) ? edge_m1 : item.coord_i - 5'd1;
        cmd.jm  = (item.coord_j == '0) ? edge_m1 : item.coord_j - 5'd1;
        cmd.km  = (item.coord_k == '0) ? edge_m1 : item.coord_k - 5'd1;
        cmd.vec = {item.vec_x, item.vec_y, item.vec_z};
    end

endmodule

`default_nettype wire

// ===== sv/pgc_queue.sv =====
`default_nettype none

// Short command queue between front and back.
module pgc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  pgc_pkg::cmd_t       push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output pgc_pkg::cmd_t       head
);

    localparam int QD = pgc_pkg::QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    pgc_pkg::cmd_t   slot_reg [QD];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(QD));
    assign valid   = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pgc_back.sv =====
`default_nettype none

// Back end: writes loads, reads the six neighbors of a query one per cycle,
// forms the three difference sums, scales them with one shared multiplier
// and holds the result in an output register.
module pgc_back #(
    parameter int CW = 5,
    parameter int AW = 15
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [pgc_pkg::INV_W-1:0]    inv_spacing,
    input  wire logic                         cmd_valid,
    input  pgc_pkg::cmd_t                     cmd,
    output logic                              cmd_pop,
    output logic                              ram_we,
    output logic [AW-1:0]                     ram_addr,
    output logic [pgc_pkg::VEC_W-1:0]         ram_wdata,
    input  wire logic [pgc_pkg::VEC_W-1:0]    ram_rdata,
    pgc_result_if.source                      result
);

    localparam int AC = pgc_pkg::ACC_W;
    localparam int CU = pgc_pkg::CURL_W;
    localparam int FS = pgc_pkg::FRAC_SHIFT;

    pgc_pkg::state_t            state_reg, state_next;
    logic [2:0]                 step_reg, step_next;
    logic [1:0]                 mstep_reg, mstep_next;
    pgc_pkg::cmd_t              cmd_reg;
    logic signed [AC-1:0]       acc_x_reg, acc_x_next;
    logic signed [AC-1:0]       acc_y_reg, acc_y_next;
    logic signed [AC-1:0]       acc_z_reg, acc_z_next;
    logic signed [CU-1:0]       cx_reg, cy_reg, cz_reg;
    logic                       out_valid_reg;
    logic signed [CU-1:0]       out_x_reg, out_y_reg, out_z_reg;
    logic                       out_err_reg;

    logic                       out_free;
    logic                       start_query;
    logic                       emit_error;
    logic                       emit_curl;
    logic [2:0]                 prev_step;
    logic signed [AC-1:0]       vx, vy, vz;
    logic signed [AC-1:0]       mul_a;
    logic signed [pgc_pkg::PROD_W-1:0] prod;
    logic signed [CU-1:0]       scaled;
    logic [pgc_pkg::COORD_W-1:0] ri, rj, rk;

    assign out_free = !out_valid_reg || result.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pgc_pkg::S_IDLE:
            begin
                if (cmd_valid && (cmd.op == pgc_pkg::OP_QUERY))
                begin
                    state_next = pgc_pkg::S_READ;
                end
            end
            pgc_pkg::S_READ:
            begin
                if (step_reg == pgc_pkg::RD_LAST)
                begin
                    state_next = pgc_pkg::S_MUL;
                end
            end
            pgc_pkg::S_MUL:
            begin
                if (mstep_reg == pgc_pkg::MUL_LAST)
                begin
                    state_next = pgc_pkg::S_DONE;
                end
            end
            pgc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = pgc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pgc_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs: queue pop, memory write and result loads.
    always_comb
    begin
        cmd_pop     = 1'b0;
        ram_we      = 1'b0;
        start_query = 1'b0;
        emit_error  = 1'b0;
        emit_curl   = 1'b0;
        case (state_reg)
            pgc_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        pgc_pkg::OP_LOAD:
                        begin
                            cmd_pop = 1'b1;
                            ram_we  = 1'b1;
                        end
                        pgc_pkg::OP_QUERY:
                        begin
                            cmd_pop     = 1'b1;
                            start_query = 1'b1;
                        end
                        pgc_pkg::OP_ERROR:
                        begin
                            cmd_pop    = out_free;
                            emit_error = out_free;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            pgc_pkg::S_DONE:
            begin
                emit_curl = out_free;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Memory address: the load point, or the neighbor of the current read.
    always_comb
    begin
        ri = cmd_reg.ci;
        rj = cmd_reg.cj;
        rk = cmd_reg.ck;
        case (step_reg)
            pgc_pkg::RD_JP: rj = cmd_reg.jp;
            pgc_pkg::RD_JM: rj = cmd_reg.jm;
            pgc_pkg::RD_KP: rk = cmd_reg.kp;
            pgc_pkg::RD_KM: rk = cmd_reg.km;
            pgc_pkg::RD_IP: ri = cmd_reg.ip;
            pgc_pkg::RD_IM: ri = cmd_reg.im;
            default:        ri = cmd_reg.ci;
        endcase
        if (state_reg == pgc_pkg::S_IDLE)
        begin
            ram_addr = {cmd.ci[CW-1:0], cmd.cj[CW-1:0], cmd.ck[CW-1:0]};
        end
        else
        begin
            ram_addr = {ri[CW-1:0], rj[CW-1:0], rk[CW-1:0]};
        end
        ram_wdata = cmd.vec;
    end

    // Difference sums: each read brings one neighbor, used by two components.
    always_comb
    begin
        vx = AC'($signed(ram_rdata[3*pgc_pkg::COMP_W-1:2*pgc_pkg::COMP_W]));
        vy = AC'($signed(ram_rdata[2*pgc_pkg::COMP_W-1:pgc_pkg::COMP_W]));
        vz = AC'($signed(ram_rdata[pgc_pkg::COMP_W-1:0]));
        prev_step  = step_reg - 3'd1;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        acc_z_next = acc_z_reg;
        step_next  = step_reg;
        if (start_query)
        begin
            acc_x_next = '0;
            acc_y_next = '0;
            acc_z_next = '0;
            step_next  = '0;
        end
        else if (state_reg == pgc_pkg::S_READ)
        begin
            step_next = step_reg + 3'd1;
            if (step_reg != '0)
            begin
                case (prev_step)
                    pgc_pkg::RD_JP:
                    begin
                        acc_x_next = acc_x_reg + vz;
                        acc_z_next = acc_z_reg - vx;
                    end
                    pgc_pkg::RD_JM:
                    begin
                        acc_x_next = acc_x_reg - vz;
                        acc_z_next = acc_z_reg + vx;
                    end
                    pgc_pkg::RD_KP:
                    begin
                        acc_x_next = acc_x_reg - vy;
                        acc_y_next = acc_y_reg + vx;
                    end
                    pgc_pkg::RD_KM:
                    begin
                        acc_x_next = acc_x_reg + vy;
                        acc_y_next = acc_y_reg - vx;
                    end
                    pgc_pkg::RD_IP:
                    begin
                        acc_y_next = acc_y_reg - vz;
                        acc_z_next = acc_z_reg + vy;
                    end
                    pgc_pkg::RD_IM:
                    begin
                        acc_y_next = acc_y_reg + vz;
                        acc_z_next = acc_z_reg - vy;
                    end
                    default:
                    begin
                        acc_x_next = acc_x_reg;
                    end
                endcase
            end
        end
    end

    // Shared scaling multiplier; the arithmetic shift rounds toward minus infinity.
    always_comb
    begin
        case (mstep_reg)
            2'd0:    mul_a = acc_x_reg;
            2'd1:    mul_a = acc_y_reg;
            default: mul_a = acc_z_reg;
        endcase
        prod       = mul_a * $signed({1'b0, inv_spacing});
        scaled     = prod[FS+CU-1:FS];
        mstep_next = (state_reg == pgc_pkg::S_MUL) ? mstep_reg + 2'd1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pgc_pkg::S_IDLE;
            step_reg      <= '0;
            mstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mstep_reg <= mstep_next;
            if (emit_error || emit_curl)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        acc_z_reg <= acc_z_next;
        if (start_query)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == pgc_pkg::S_MUL)
        begin
            case (mstep_reg)
                2'd0:    cx_reg <= scaled;
                2'd1:    cy_reg <= scaled;
                default: cz_reg <= scaled;
            endcase
        end
        if (emit_error)
        begin
            out_x_reg   <= '0;
            out_y_reg   <= '0;
            out_z_reg   <= '0;
            out_err_reg <= 1'b1;
        end
        else if (emit_curl)
        begin
            out_x_reg   <= cx_reg;
            out_y_reg   <= cy_reg;
            out_z_reg   <= cz_reg;
            out_err_reg <= 1'b0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.curl_x      = out_x_reg;
    assign result.curl_y      = out_y_reg;
    assign result.curl_z      = out_z_reg;
    assign result.coord_error = out_err_reg;

endmodule

`default_nettype wire

// ===== sv/periodic_grid_curl_stencil_top.sv =====
// Channel   Dir   Handshake        Payload
// item      in    valid / ready    kind, coord_i, coord_j, coord_k, vec_x, vec_y, vec_z
// result    out   valid / ready    curl_x, curl_y, curl_z, coord_error
// cfg       in    cfg_we           cfg_index, cfg_data (grid_size, inv_spacing)
//
// In the back end a load is written to memory and an out-of-grid query is passed
// to the output register as an error result, both straight from idle. An in-grid
// query runs six neighbor reads through the single memory port (the read data is
// registered), three multiplier steps and the hand-off to the output register.
// Items enter a two-deep queue, so the input side keeps taking transfers, until it
// is full, while the back end works or the result waits. Reset clears control
// state only; the sample memory holds no defined value until a point is loaded.
`default_nettype none

module periodic_grid_curl_stencil_top #(
    parameter int EDGE_MAX = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    pgc_item_if.sink                                item,
    pgc_result_if.source                            result,
    input  wire logic                               cfg_we,
    input  wire logic [pgc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pgc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LIMIT = (EDGE_MAX < 32) ? EDGE_MAX : 32;
    localparam int CW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;

    logic [pgc_pkg::GRID_W-1:0] grid_size_reg;
    logic [pgc_pkg::INV_W-1:0]  inv_spacing_reg;

    logic                       push;
    pgc_pkg::cmd_t              push_cmd;
    logic                       full;
    logic                       cmd_valid;
    pgc_pkg::cmd_t              head;
    logic                       cmd_pop;
    logic                       ram_we;
    logic [AW-1:0]              ram_addr;
    logic [pgc_pkg::VEC_W-1:0]  ram_wdata;
    logic [pgc_pkg::VEC_W-1:0]  ram_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg   <= pgc_pkg::GRID_SIZE_RESET;
            inv_spacing_reg <= pgc_pkg::INV_SPACING_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pgc_pkg::REG_GRID_SIZE)
            begin
                grid_size_reg <= cfg_data[pgc_pkg::GRID_W-1:0];
            end
            if (cfg_index == pgc_pkg::REG_INV_SPACING)
            begin
                inv_spacing_reg <= cfg_data[pgc_pkg::INV_W-1:0];
            end
        end
    end

    pgc_front #(
        .EDGE_MAX (EDGE_MAX)
    ) u_front (
        .item      (item),
        .grid_size (grid_size_reg),
        .full      (full),
        .push      (push),
        .cmd       (push_cmd)
    );

    pgc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (cmd_pop),
        .valid    (cmd_valid),
        .head     (head)
    );

    pgc_ram #(
        .WIDTH (pgc_pkg::VEC_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    pgc_back #(
        .CW (CW),
        .AW (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .inv_spacing (inv_spacing_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (head),
        .cmd_pop     (cmd_pop),
        .ram_we      (ram_we),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .ram_rdata   (ram_rdata),
        .result      (result)
    );

endmodule

`default_nettype wire

// ===== sv/pgc_checker.sv =====
`default_nettype none

// Port-level checks of the curl stencil block.
module pgc_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    input  wire logic                              item_ready,
    input  wire logic                              item_kind,
    input  wire logic                              result_valid,
    input  wire logic                              result_ready,
    input  wire logic signed [pgc_pkg::CURL_W-1:0] curl_x,
    input  wire logic signed [pgc_pkg::CURL_W-1:0] curl_y,
    input  wire logic signed [pgc_pkg::CURL_W-1:0] curl_z,
    input  wire logic                              coord_error
);

    // Queue slots, the item in the back end and the output register.
    localparam int MAX_OPEN = pgc_pkg::QUEUE_DEPTH + 2;
    localparam int OW       = $clog2(MAX_OPEN + 2);

    logic [OW-1:0] open_reg, open_next;
    logic          query_in;
    logic          result_out;

    assign query_in   = item_valid && item_ready && (item_kind == pgc_pkg::KIND_QUERY);
    assign result_out = result_valid && result_ready;

    // Count of queries accepted but not yet delivered.
    always_comb
    begin
        open_next = open_reg + OW'(query_in) - OW'(result_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // A stalled result keeps its flag and values.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(curl_x) && $stable(curl_y) &&
            $stable(curl_z) && $stable(coord_error))
    else $error("result changed while stalled");

    // An error result carries zero curl values.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && coord_error |-> curl_x == '0 && curl_y == '0 && curl_z == '0)
    else $error("error result with nonzero curl");

    // Every result answers an accepted query.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> open_reg != '0)
    else $error("result without an open query");

    // The block never holds more queries than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= OW'(MAX_OPEN))
    else $error("too many open queries");

endmodule

bind periodic_grid_curl_stencil_top pgc_checker u_pgc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_kind    (item.kind),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .curl_x       (result.curl_x),
    .curl_y       (result.curl_y),
    .curl_z       (result.curl_z),
    .coord_error  (result.coord_error)
);

`default_nettype wire
